### src/assert_macros.svh
// Assertion macros shared by the files that carry checks.
// Each check is sampled on the rising edge of clk and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every sampled edge.
`define CHECK_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A trigger that implies a condition at the same edge.
`define CHECK_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

### src/mlc_pkg.sv
// ----------------------------------------------------------------------------
// mlc_pkg: shared types and tables of the modem line classifier
// Line types, prefix pattern tables, widths and small helper functions.
// ----------------------------------------------------------------------------
package mlc_pkg;

	localparam int MaxLine      = 1023;
	localparam int LenBits      = $clog2(MaxLine + 1);
	localparam int LineLenBits  = 10;
	localparam int CountBits    = 32;
	localparam int OutCountBits = 32;
	localparam int ByteBits     = 8;
	localparam int NumTypes     = 5;
	localparam int TypeBits     = 3;
	localparam int PrioBits     = 2;
	localparam int NumPatterns  = 16;
	localparam int PatChars     = 8;
	localparam int PatIdxBits   = $clog2(PatChars);

	localparam logic [ByteBits-1:0] ChCr = 8'd13;
	localparam logic [ByteBits-1:0] ChLf = 8'd10;

	typedef logic [ByteBits-1:0] byte_t;

	typedef enum logic [TypeBits-1:0] {
		TypeGps     = 3'd0,
		TypeCell    = 3'd1,
		TypeMqtt    = 3'd2,
		TypeAt      = 3'd3,
		TypeUnknown = 3'd4
	} line_type_t;

	// Result of the matcher for the byte held in the input register.
	typedef struct packed {
		logic               emit;
		line_type_t         kind;
		logic [LenBits-1:0] length;
	} mlc_info_t;

	localparam byte_t Nul = 8'h00;

	// Pattern characters, padded with NUL; padding is never compared.
	localparam byte_t PatText [NumPatterns][PatChars] = '{
		'{"$", "G", "P", Nul, Nul, Nul, Nul, Nul},
		'{"$", "G", "L", Nul, Nul, Nul, Nul, Nul},
		'{"$", "G", "A", Nul, Nul, Nul, Nul, Nul},
		'{"$", "G", "B", Nul, Nul, Nul, Nul, Nul},
		'{"$", "G", "N", Nul, Nul, Nul, Nul, Nul},
		'{"+", "C", "R", "E", "G", Nul, Nul, Nul},
		'{"+", "C", "S", "Q", Nul, Nul, Nul, Nul},
		'{"+", "C", "O", "P", "S", Nul, Nul, Nul},
		'{"+", "C", "G", "A", "T", "T", Nul, Nul},
		'{"+", "C", "F", "U", "N", Nul, Nul, Nul},
		'{"+", "C", "P", "I", "N", Nul, Nul, Nul},
		'{"+", "C", "M", "Q", "T", "T", Nul, Nul},
		'{"O", "K", Nul, Nul, Nul, Nul, Nul, Nul},
		'{"E", "R", "R", "O", "R", Nul, Nul, Nul},
		'{"R", "E", "A", "D", "Y", Nul, Nul, Nul},
		'{"A", "T", "+", Nul, Nul, Nul, Nul, Nul}
	};

	localparam logic [PatIdxBits-1:0] PatLen [NumPatterns] = '{
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd5, 3'd4, 3'd5, 3'd6, 3'd5, 3'd5,
		3'd6,
		3'd2, 3'd5, 3'd5, 3'd3
	};

	// Set where the line must equal the pattern rather than start with it.
	localparam logic [NumPatterns-1:0] PatWhole = 16'b0111_0000_0000_0000;

	localparam line_type_t PatKind [NumPatterns] = '{
		TypeGps, TypeGps, TypeGps, TypeGps, TypeGps,
		TypeCell, TypeCell, TypeCell, TypeCell, TypeCell, TypeCell,
		TypeMqtt,
		TypeAt, TypeAt, TypeAt, TypeAt
	};

	localparam logic [NumPatterns-1:0] AllAlive = '1;

	function automatic logic [PrioBits-1:0] prio_of(input line_type_t kind);
		logic [PrioBits-1:0] p;
		unique case (kind)
			TypeGps:  p = 2'd0;
			TypeCell: p = 2'd1;
			TypeMqtt: p = 2'd1;
			TypeAt:   p = 2'd2;
			default:  p = 2'd3;
		endcase
		return p;
	endfunction

	function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

endpackage

### src/mlc_matcher.sv
// ----------------------------------------------------------------------------
// mlc_matcher: line length and prefix pattern tracking
// Holds the open line's length and the mask of patterns still matching, and
// classifies the line when the held byte is a line end.
// ----------------------------------------------------------------------------
module mlc_matcher (
	input  logic                clk,
	input  logic                arst_n,
	input  mlc_pkg::byte_t      byte_s1,
	input  logic                step,
	output mlc_pkg::mlc_info_t  info
);
	import mlc_pkg::*;

	logic [LenBits-1:0]     length_q;
	logic [NumPatterns-1:0] alive_q;
	logic [NumPatterns-1:0] keep;
	logic [NumPatterns-1:0] hit;
	line_type_t             kind;
	logic                   is_end;

	assign is_end = (byte_s1 == ChCr) || (byte_s1 == ChLf);

	always_comb begin
		for (int i = 0; i < NumPatterns; i++) begin
			if (length_q < LenBits'(PatLen[i])) begin
				keep[i] = (PatText[i][length_q[PatIdxBits-1:0]] == byte_s1);
			end else begin
				keep[i] = !PatWhole[i];
			end
			if (PatWhole[i]) begin
				hit[i] = alive_q[i] && (length_q == LenBits'(PatLen[i]));
			end else begin
				hit[i] = alive_q[i] && (length_q >= LenBits'(PatLen[i]));
			end
		end
	end

	// The lowest-numbered matching pattern decides the type.
	always_comb begin
		kind = TypeUnknown;
		for (int i = NumPatterns - 1; i >= 0; i--) begin
			if (hit[i]) begin
				kind = PatKind[i];
			end
		end
	end

	assign info.emit   = is_end && (length_q != '0);
	assign info.kind   = kind;
	assign info.length = length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			alive_q  <= AllAlive;
		end else if (step) begin
			if (is_end) begin
				length_q <= '0;
				alive_q  <= AllAlive;
			end else begin
				alive_q <= alive_q & keep;
				if (length_q < LenBits'(MaxLine)) begin
					length_q <= length_q + 1'b1;
				end
			end
		end
	end

endmodule

### src/modem_line_classifier_top.sv
// ----------------------------------------------------------------------------
// modem_line_classifier_top: modem receive line splitter and classifier
// Splits received bytes into lines at CR or LF, classifies each non-empty
// line and reports type, priority, length, routing and saturating counts.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  rx_byte
//  result   out        out_valid/out_stall  line_type, priority_res, line_length,
//                                           routed, type_count, total_count
//  config   in         cfg_valid/cfg_ready  route_mask
//
// One byte is taken every cycle while in_stall is low. A byte is held in the
// input register while the matcher and counter update work on it; a line end's
// result is then loaded into the output register, from which it can be taken.
// Reset clears the line state, the counters and the routing mask.
// While a result waits under out_stall, bytes keep passing the input register;
// in_stall rises only while the held byte ends a non-empty line.
`include "assert_macros.svh"

module modem_line_classifier_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mlc_pkg::ByteBits-1:0]      rx_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mlc_pkg::TypeBits-1:0]      line_type,
	output logic [mlc_pkg::PrioBits-1:0]      priority_res,
	output logic [mlc_pkg::LineLenBits-1:0]   line_length,
	output logic                              routed,
	output logic [mlc_pkg::OutCountBits-1:0]  type_count,
	output logic [mlc_pkg::OutCountBits-1:0]  total_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mlc_pkg::NumTypes-1:0]      route_mask
);
	import mlc_pkg::*;

	logic                 valid_s1;
	byte_t                byte_s1;
	mlc_info_t            info;
	logic                 advance;
	logic                 fire;
	logic                 out_free;
	logic [NumTypes-1:0]  route_q;
	logic [CountBits-1:0] type_cnt_q [NumTypes];
	logic [CountBits-1:0] total_q;
	logic [CountBits-1:0] type_next;
	logic [CountBits-1:0] total_next;

	mlc_matcher u_matcher (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.step    (advance),
		.info    (info)
	);

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;
	// Only a line end that yields a result needs room in the output register.
	assign advance   = valid_s1 && (!info.emit || out_free);
	assign fire      = advance && info.emit;
	assign in_stall  = valid_s1 && !advance;

	assign type_next  = sat_inc(type_cnt_q[info.kind]);
	assign total_next = sat_inc(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && !in_stall) || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			route_q <= route_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int t = 0; t < NumTypes; t++) begin
				type_cnt_q[t] <= '0;
			end
		end else if (fire) begin
			total_q                <= total_next;
			type_cnt_q[info.kind] <= type_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			line_type    <= info.kind;
			priority_res <= prio_of(info.kind);
			line_length  <= LineLenBits'(info.length);
			routed       <= route_q[info.kind];
			type_count   <= OutCountBits'(type_next);
			total_count  <= OutCountBits'(total_next);
		end
	end

	`CHECK_IMPLY(a_stall_has_word, in_stall, valid_s1, "stall with no word")
	`CHECK_IMPLY(a_total_covers_type, out_valid, total_count >= type_count, "type above total")
	`CHECK_IMPLY(a_prio_matches, out_valid, priority_res == prio_of(line_type_t'(line_type)), "bad prio")
	`CHECK_IMPLY(a_len_nonzero, out_valid, line_length != '0, "empty line reported")

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the modem line classifier
// Feeds modem receive bytes as whole lines and noise, with random idling on
// both sides, predicts each line report and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import mlc_pkg::*;

	localparam int WatchdogLimit = 3000;
	localparam int DrainCycles   = 8;
	localparam int PhaseBytes    = 150;

	typedef struct {
		line_type_t  kind;
		logic [1:0]  prio;
		logic [9:0]  len;
		logic        routed;
		logic [31:0] type_cnt;
		logic [31:0] total_cnt;
	} line_report_t;

	// One directed line: text, then nfill copies of fill, then the terminator.
	// Where typed is set, type and length are given here rather than predicted.
	typedef struct {
		string      text;
		byte_t      fill;
		int         nfill;
		byte_t      term;
		bit         typed;
		line_type_t kind;
		int         len;
	} line_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	byte_t       rx_byte   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  line_type;
	logic [1:0]  priority_res;
	logic [9:0]  line_length;
	logic        routed;
	logic [31:0] type_count;
	logic [31:0] total_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_mask  = '0;

	modem_line_classifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_type    (line_type),
		.priority_res (priority_res),
		.line_length  (line_length),
		.routed       (routed),
		.type_count   (type_count),
		.total_count  (total_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.route_mask   (cfg_mask)
	);

	// Prefix and whole-line words, in the order in which they are tried.
	string pat_text [16] = '{"$GP", "$GL", "$GA", "$GB", "$GN",
		"+CREG", "+CSQ", "+COPS", "+CGATT", "+CFUN", "+CPIN",
		"+CMQTT", "OK", "ERROR", "READY", "AT+"};
	line_type_t pat_kind [16] = '{TypeGps, TypeGps, TypeGps, TypeGps, TypeGps,
		TypeCell, TypeCell, TypeCell, TypeCell, TypeCell, TypeCell,
		TypeMqtt, TypeAt, TypeAt, TypeAt, TypeAt};
	logic [15:0] pat_whole = 16'h7000;
	logic [1:0]  prio_by_type [5] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd3};

	// Line starts for the random part: the real words and some near misses.
	string lead_words [26] = '{"$GP", "$GL", "$GA", "$GB", "$GN",
		"+CREG", "+CSQ", "+COPS", "+CGATT", "+CFUN", "+CPIN",
		"+CMQTT", "OK", "ERROR", "READY", "AT+", "$G", "$GX", "+C",
		"+CMQT", "+CRE", "ERRO", "READ", "AT", "O", ""};

	line_row_t directed_lines [27] = '{
		'{"",             "A", 0,    ChCr, 1'b0, TypeUnknown, 0},
		'{"$GPGGA,1",     "A", 0,    ChLf, 1'b1, TypeGps,     8},
		'{"$GL",          "A", 0,    ChCr, 1'b1, TypeGps,     3},
		'{"$GAx",         "A", 0,    ChLf, 1'b1, TypeGps,     4},
		'{"$GBGSV",       "A", 0,    ChCr, 1'b1, TypeGps,     6},
		'{"$GN",          "A", 1021, ChLf, 1'b1, TypeGps,     1023},
		'{"$G",           "A", 0,    ChCr, 1'b1, TypeUnknown, 2},
		'{"+CREG: 0,1",   "A", 0,    ChCr, 1'b1, TypeCell,    10},
		'{"+CSQ",         "A", 0,    ChLf, 1'b1, TypeCell,    4},
		'{"+COPS?",       "A", 0,    ChLf, 1'b1, TypeCell,    6},
		'{"+CGATT: 1",    "A", 0,    ChCr, 1'b1, TypeCell,    9},
		'{"+CFUN",        "A", 0,    ChCr, 1'b1, TypeCell,    5},
		'{"+CPIN: READY", "A", 0,    ChLf, 1'b1, TypeCell,    12},
		'{"+CMQTT",       "A", 0,    ChCr, 1'b1, TypeMqtt,    6},
		'{"+CMQT",        "A", 0,    ChCr, 1'b1, TypeUnknown, 5},
		'{"OK",           "A", 0,    ChCr, 1'b1, TypeAt,      2},
		'{"",             "A", 0,    ChLf, 1'b0, TypeUnknown, 0},
		'{"OKAY",         "A", 0,    ChLf, 1'b1, TypeUnknown, 4},
		'{"ERROR",        "A", 0,    ChCr, 1'b1, TypeAt,      5},
		'{"READY",        "A", 0,    ChLf, 1'b1, TypeAt,      5},
		'{"ERRO",         "A", 0,    ChLf, 1'b1, TypeUnknown, 4},
		'{"AT+CSQ",       "A", 0,    ChCr, 1'b1, TypeAt,      6},
		'{"AT",           "A", 0,    ChCr, 1'b1, TypeUnknown, 2},
		'{"",             8'h00, 3,  ChLf, 1'b1, TypeUnknown, 3},
		'{"",             8'hFF, 2,  ChCr, 1'b1, TypeUnknown, 2},
		'{"X",            "q", 6,    ChLf, 1'b1, TypeUnknown, 7},
		'{"OK",           8'h00, 1,  ChCr, 1'b0, TypeUnknown, 0}
	};

	// Predictor state.
	int          open_len = 0;
	logic [15:0] alive    = '1;
	logic [31:0] type_lines [5] = '{default: '0};
	logic [31:0] all_lines = '0;
	logic [4:0]  route_bits = '0;

	line_report_t pending_reports [$];
	int  errors      = 0;
	int  fed_bytes   = 0;
	int  idle_cycles = 0;
	bit  steady      = 1'b0;
	int  stall_hold  = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Works out the report, if any, that one byte causes and advances the state.
	task automatic classify_byte(input byte_t b, output bit got, output line_report_t rep);
		line_type_t k;
		bit found, keep;
		int i, plen;
		got = 1'b0;
		rep.kind = TypeUnknown;
		rep.prio = '0;
		rep.len = '0;
		rep.routed = 1'b0;
		rep.type_cnt = '0;
		rep.total_cnt = '0;
		if (b == ChCr || b == ChLf) begin
			if (open_len != 0) begin
				k = TypeUnknown;
				found = 1'b0;
				for (i = 0; i < 16; i++) begin
					plen = pat_text[i].len();
					if (!found && alive[i] &&
					    (pat_whole[i] ? open_len == plen : open_len >= plen)) begin
						found = 1'b1;
						k = pat_kind[i];
					end
				end
				if (~&type_lines[k])
					type_lines[k] = type_lines[k] + 1;
				if (~&all_lines)
					all_lines = all_lines + 1;
				got = 1'b1;
				rep.kind = k;
				rep.prio = prio_by_type[k];
				rep.len = open_len[9:0];
				rep.routed = route_bits[k];
				rep.type_cnt = type_lines[k];
				rep.total_cnt = all_lines;
				open_len = 0;
				alive = '1;
			end
		end else begin
			for (i = 0; i < 16; i++) begin
				plen = pat_text[i].len();
				if (open_len < plen)
					keep = (pat_text[i][open_len] == b);
				else
					keep = !pat_whole[i];
				if (!keep)
					alive[i] = 1'b0;
			end
			if (open_len < MaxLine)
				open_len++;
		end
	endtask

	// Offers one byte, waits for it to be taken and predicts its effect.
	task automatic send_byte(input byte_t b, output bit got, output line_report_t rep);
		int gap;
		gap = steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		fed_bytes++;
		classify_byte(b, got, rep);
	endtask

	task automatic feed(input byte_t b);
		bit got;
		line_report_t rep;
		send_byte(b, got, rep);
		if (got)
			pending_reports.push_back(rep);
	endtask

	// Writes the routing mask once the block has nothing left in flight.
	task automatic write_mask(input logic [4:0] m);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		// A byte that ends no line may still be in the input register.
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_mask <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		route_bits = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_line();
		string lead;
		int i, tail, r, v;
		lead = lead_words[$urandom_range(0, 25)];
		r = $urandom_range(0, 99);
		if (r < 35 && (lead == "OK" || lead == "ERROR" || lead == "READY"))
			tail = 0;
		else if (r < 70)
			tail = $urandom_range(0, 6);
		else if (r < 95)
			tail = $urandom_range(7, 30);
		else
			tail = $urandom_range(31, 80);
		for (i = 0; i < lead.len(); i++)
			feed(lead[i]);
		for (i = 0; i < tail; i++) begin
			v = $urandom_range(0, 255);
			if (v == ChCr || v == ChLf)
				v = v + 1;
			feed(v[7:0]);
		end
		r = $urandom_range(0, 2);
		if (r == 0)
			feed(ChCr);
		else if (r == 1)
			feed(ChLf);
		else begin
			feed(ChCr);
			feed(ChLf);
		end
	endtask

	task automatic check_field(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : report_check
		line_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected report, expected none, got type %0d length %0d",
					$time, line_type, line_length);
			end else begin
				want = pending_reports.pop_front();
				check_field("line_type", want.kind, line_type);
				check_field("priority_res", want.prio, priority_res);
				check_field("line_length", want.len, line_length);
				check_field("routed", want.routed, routed);
				check_field("type_count", want.type_cnt, type_count);
				check_field("total_count", want.total_cnt, total_count);
			end
		end
	end

	// The receiver holds each stall or release level for a random run.
	always @(negedge clk) begin
		if (steady || !arst_n) begin
			out_stall <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold == 0) begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_hold <= pick_gap();
		end else begin
			stall_hold <= stall_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [4:0] phase_masks [5];
		bit got;
		line_report_t rep;
		int row, i, phase, stop_at, n;
		phase_masks[0] = 5'h1F;
		phase_masks[1] = 5'h00;
		phase_masks[2] = 5'($urandom_range(0, 31));
		phase_masks[3] = 5'($urandom_range(0, 31));
		phase_masks[4] = 5'h0A;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		write_mask(5'h15);
		for (row = 0; row < 27; row++) begin
			for (i = 0; i < directed_lines[row].text.len(); i++)
				feed(directed_lines[row].text[i]);
			for (i = 0; i < directed_lines[row].nfill; i++)
				feed(directed_lines[row].fill);
			send_byte(directed_lines[row].term, got, rep);
			if (got) begin
				if (directed_lines[row].typed) begin
					rep.kind = directed_lines[row].kind;
					rep.prio = prio_by_type[directed_lines[row].kind];
					rep.len = directed_lines[row].len[9:0];
				end
				pending_reports.push_back(rep);
			end
		end

		for (phase = 0; phase < 5; phase++) begin
			write_mask(phase_masks[phase]);
			steady = (phase == 1);
			stop_at = fed_bytes + PhaseBytes;
			while (fed_bytes < stop_at) begin
				if ($urandom_range(0, 99) < 15) begin
					// Noise: arbitrary bytes, line ends included now and then.
					n = $urandom_range(1, 8);
					for (i = 0; i < n; i++) begin
						if ($urandom_range(0, 9) == 0)
							feed($urandom_range(0, 1) ? ChCr : ChLf);
						else
							feed(8'($urandom_range(0, 255)));
					end
				end else begin
					send_random_line();
				end
			end
			steady = 1'b0;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### modem_line_classifier_top.f
+incdir+src
src/mlc_pkg.sv
src/mlc_matcher.sv
src/modem_line_classifier_top.sv
dv/tb_top.sv
